[src/gelu_tanh_derivative_top_defines.svh]
// Assertion helpers shared by the RTL files.
`ifndef GELU_TANH_DERIVATIVE_TOP_DEFINES_SVH
`define GELU_TANH_DERIVATIVE_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define GTD_ASSERT_IMP(LBL, A, C) \
    LBL: assert property (@(posedge clk) disable iff (!rst_n) (A) |-> (C)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define GTD_ASSERT_NXT(LBL, A, C) \
    LBL: assert property (@(posedge clk) disable iff (!rst_n) (A) |=> (C)) \
        else $error("%m: next-cycle check failed");

`endif

[src/gtd_pkg.sv]
`default_nettype none
package gtd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int IN_FRAC      = SAMPLE_WIDTH - 5;
    localparam int OUT_FRAC     = SAMPLE_WIDTH - 3;
    localparam int ZQ           = 20;
    localparam int YQ           = 24;
    localparam int EQ           = 30;
    localparam int ZSH          = ZQ - IN_FRAC;

    localparam int EXP_TERMS    = 12;
    localparam int DIV_BITS     = 30;

    // internal widths
    localparam int ZM_W   = SAMPLE_WIDTH + ZSH;
    localparam int ZZ_W   = 33;
    localparam int P1_W   = 29;
    localparam int P2_W   = 30;
    localparam int M1_W   = 33;
    localparam int M2_W   = 34;
    localparam int Y1_W   = 34;
    localparam int Y2_W   = 35;
    localparam int X_W    = 34;
    localparam int N_W    = 5;
    localparam int R_W    = 30;
    localparam int ACC_W  = 31;
    localparam int V_W    = 30;
    localparam int RCP_W  = 33;
    localparam int K_W    = 4;
    localparam int D_W    = 32;
    localparam int LO_W   = DIV_BITS;
    localparam int YT_W   = 30;

    localparam logic [20:0] K4      = 21'd1197135;
    localparam logic [21:0] K5      = 22'd3591405;
    localparam logic [24:0] KC      = 25'd26772563;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;
    // floor(2^36 / LN2_Q30): quotient estimate for the range reduction
    localparam logic [6:0]  LN2_RCP = 7'd92;

    localparam logic [ACC_W-1:0] ONE_Q30 = ACC_W'(1) << EQ;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] z_sample;
        logic                           last_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] derivative;
        logic                           last_out;
    } out_t;

    // Per-sample data that rides along the cell chains.
    typedef struct packed {
        logic            last;
        logic            neg;
        logic            sat;
        logic [YT_W-1:0] y2m;
        logic [N_W-1:0]  n;
    } side_t;

    // floor(2^32 / k) for the Horner divisors 1..12
    function automatic logic [RCP_W-1:0] exp_rcp(input logic [K_W-1:0] k);
        logic [RCP_W-1:0] m;
        case (k)
            4'd1:    m = 33'd4294967296;
            4'd2:    m = 33'd2147483648;
            4'd3:    m = 33'd1431655765;
            4'd4:    m = 33'd1073741824;
            4'd5:    m = 33'd858993459;
            4'd6:    m = 33'd715827882;
            4'd7:    m = 33'd613566756;
            4'd8:    m = 33'd536870912;
            4'd9:    m = 33'd477218588;
            4'd10:   m = 33'd429496729;
            4'd11:   m = 33'd390451572;
            4'd12:   m = 33'd357913941;
            default: m = 33'd0;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

[src/gelu_tanh_derivative_top.sv]
// Channel  | Ports                      | Handshake
// ---------+----------------------------+------------------------------------
// sample   | start, busy, sample        | beat taken when start & !busy
// result   | done, result               | beat shown one cycle, done marks it
//
// One sample enters per clock; busy stays low, as the pipeline never stalls.
// Results appear in the same order as their start beats.
// The pipeline holds the 12 three-stage Horner cells of the exp series and
// the 30 one-bit cells of the sigmoid division.
// Reset clears only the valid bits of the pipeline; payload flows unreset.
// The receiver cannot stall: every done beat is taken at once.
`default_nettype none
`include "gelu_tanh_derivative_top_defines.svh"
module gelu_tanh_derivative_top (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    output logic                busy,
    input  wire gtd_pkg::in_t   sample,
    output logic                done,
    output gtd_pkg::out_t       result
);

    localparam int SW = gtd_pkg::SAMPLE_WIDTH;

    // The pipeline never holds off input.
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // s1: magnitude, sign, move |z| to Q.20
    // ------------------------------------------------------------------
    logic [SW-1:0]              s1_mag;
    logic                       s1_neg;
    logic                       s1_valid_reg;
    logic                       s1_neg_reg;
    logic                       s1_last_reg;
    logic [gtd_pkg::ZM_W-1:0]   s1_zm_reg;

    assign s1_neg = sample.z_sample[SW-1];
    assign s1_mag = s1_neg ? SW'(-sample.z_sample) : SW'(sample.z_sample);

    // ------------------------------------------------------------------
    // s2: zz = rshr(zm^2, 16)
    // ------------------------------------------------------------------
    localparam int ZSQ_W = 2 * gtd_pkg::ZM_W;
    logic [ZSQ_W-1:0]           s2_sq;
    logic [gtd_pkg::ZZ_W-1:0]   s2_zz_next;
    logic                       s2_valid_reg;
    logic                       s2_neg_reg;
    logic                       s2_last_reg;
    logic [gtd_pkg::ZM_W-1:0]   s2_zm_reg;
    logic [gtd_pkg::ZZ_W-1:0]   s2_zz_reg;

    assign s2_sq      = ZSQ_W'(s1_zm_reg) * ZSQ_W'(s1_zm_reg);
    assign s2_zz_next = gtd_pkg::ZZ_W'((s2_sq + (ZSQ_W'(1) << 15)) >> 16);

    // ------------------------------------------------------------------
    // s3: polynomial factors p1, p2
    // ------------------------------------------------------------------
    localparam int PR_W = 56;
    logic [PR_W-1:0]            s3_pr1;
    logic [PR_W-1:0]            s3_pr2;
    logic [gtd_pkg::P1_W-1:0]   s3_p1_next;
    logic [gtd_pkg::P2_W-1:0]   s3_p2_next;
    logic                       s3_valid_reg;
    logic                       s3_neg_reg;
    logic                       s3_last_reg;
    logic [gtd_pkg::ZM_W-1:0]   s3_zm_reg;
    logic [gtd_pkg::P1_W-1:0]   s3_p1_reg;
    logic [gtd_pkg::P2_W-1:0]   s3_p2_reg;

    assign s3_pr1     = PR_W'(s2_zz_reg) * PR_W'(gtd_pkg::K4);
    assign s3_pr2     = PR_W'(s2_zz_reg) * PR_W'(gtd_pkg::K5);
    assign s3_p1_next = gtd_pkg::P1_W'((PR_W'(1) << gtd_pkg::YQ)
                        + ((s3_pr1 + (PR_W'(1) << 23)) >> gtd_pkg::YQ));
    assign s3_p2_next = gtd_pkg::P2_W'((PR_W'(1) << gtd_pkg::YQ)
                        + ((s3_pr2 + (PR_W'(1) << 23)) >> gtd_pkg::YQ));

    // ------------------------------------------------------------------
    // s4: m = rshr(zm * p, 20)
    // ------------------------------------------------------------------
    localparam int MP_W = 56;
    logic [MP_W-1:0]            s4_mp1;
    logic [MP_W-1:0]            s4_mp2;
    logic                       s4_valid_reg;
    logic                       s4_neg_reg;
    logic                       s4_last_reg;
    logic [gtd_pkg::M1_W-1:0]   s4_m1_reg;
    logic [gtd_pkg::M2_W-1:0]   s4_m2_reg;

    assign s4_mp1 = MP_W'(s3_zm_reg) * MP_W'(s3_p1_reg);
    assign s4_mp2 = MP_W'(s3_zm_reg) * MP_W'(s3_p2_reg);

    // ------------------------------------------------------------------
    // s5: |y| = rshr(m * KC, 24)
    // ------------------------------------------------------------------
    localparam int YP_W = 60;
    logic [YP_W-1:0]            s5_yp1;
    logic [YP_W-1:0]            s5_yp2;
    logic                       s5_valid_reg;
    logic                       s5_neg_reg;
    logic                       s5_last_reg;
    logic [gtd_pkg::Y1_W-1:0]   s5_y1_reg;
    logic [gtd_pkg::Y2_W-1:0]   s5_y2_reg;

    assign s5_yp1 = YP_W'(s4_m1_reg) * YP_W'(gtd_pkg::KC);
    assign s5_yp2 = YP_W'(s4_m2_reg) * YP_W'(gtd_pkg::KC);

    // ------------------------------------------------------------------
    // s6: overflow flag, x in Q.30, estimate n = x / ln2
    // ------------------------------------------------------------------
    localparam int XQ_W = gtd_pkg::X_W + 7;
    localparam logic [gtd_pkg::Y1_W-1:0] Y1_LIMIT = gtd_pkg::Y1_W'(16) << gtd_pkg::YQ;
    logic [gtd_pkg::X_W-1:0]    s6_x;
    logic [XQ_W-1:0]            s6_xq;
    logic                       s6_valid_reg;
    logic                       s6_neg_reg;
    logic                       s6_last_reg;
    logic                       s6_sat_reg;
    logic [gtd_pkg::YT_W-1:0]   s6_y2_reg;
    logic [gtd_pkg::X_W-1:0]    s6_x_reg;
    logic [gtd_pkg::N_W-1:0]    s6_q0_reg;

    assign s6_x  = {s5_y1_reg[27:0], 6'b0};
    assign s6_xq = XQ_W'(s6_x) * XQ_W'(gtd_pkg::LN2_RCP);

    // ------------------------------------------------------------------
    // s7: correct n by one, remainder r = x - n*ln2
    // ------------------------------------------------------------------
    logic [gtd_pkg::X_W-1:0]    s7_prod;
    logic [gtd_pkg::X_W-1:0]    s7_r0;
    logic                       s7_up;
    logic [gtd_pkg::N_W-1:0]    s7_n_next;
    logic [gtd_pkg::R_W-1:0]    s7_r_next;
    logic                       s7_valid_reg;
    gtd_pkg::side_t             s7_side_reg;
    logic [gtd_pkg::R_W-1:0]    s7_r_reg;

    assign s7_prod   = gtd_pkg::X_W'(s6_q0_reg) * gtd_pkg::X_W'(gtd_pkg::LN2_Q30);
    assign s7_r0     = s6_x_reg - s7_prod;
    assign s7_up     = s7_r0 >= gtd_pkg::X_W'(gtd_pkg::LN2_Q30);
    assign s7_n_next = s7_up ? s6_q0_reg + gtd_pkg::N_W'(1) : s6_q0_reg;
    assign s7_r_next = s7_up ? gtd_pkg::R_W'(s7_r0 - gtd_pkg::X_W'(gtd_pkg::LN2_Q30))
                             : gtd_pkg::R_W'(s7_r0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
            s6_valid_reg <= 1'b0;
            s7_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= start && !busy;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            s5_valid_reg <= s4_valid_reg;
            s6_valid_reg <= s5_valid_reg;
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_neg_reg  <= s1_neg;
        s1_last_reg <= sample.last_in;
        s1_zm_reg   <= {s1_mag, gtd_pkg::ZSH'(0)};

        s2_neg_reg  <= s1_neg_reg;
        s2_last_reg <= s1_last_reg;
        s2_zm_reg   <= s1_zm_reg;
        s2_zz_reg   <= s2_zz_next;

        s3_neg_reg  <= s2_neg_reg;
        s3_last_reg <= s2_last_reg;
        s3_zm_reg   <= s2_zm_reg;
        s3_p1_reg   <= s3_p1_next;
        s3_p2_reg   <= s3_p2_next;

        s4_neg_reg  <= s3_neg_reg;
        s4_last_reg <= s3_last_reg;
        s4_m1_reg   <= gtd_pkg::M1_W'((s4_mp1 + (MP_W'(1) << 19)) >> gtd_pkg::ZQ);
        s4_m2_reg   <= gtd_pkg::M2_W'((s4_mp2 + (MP_W'(1) << 19)) >> gtd_pkg::ZQ);

        s5_neg_reg  <= s4_neg_reg;
        s5_last_reg <= s4_last_reg;
        s5_y1_reg   <= gtd_pkg::Y1_W'((s5_yp1 + (YP_W'(1) << 23)) >> gtd_pkg::YQ);
        s5_y2_reg   <= gtd_pkg::Y2_W'((s5_yp2 + (YP_W'(1) << 23)) >> gtd_pkg::YQ);

        s6_neg_reg  <= s5_neg_reg;
        s6_last_reg <= s5_last_reg;
        s6_sat_reg  <= s5_y1_reg >= Y1_LIMIT;
        s6_y2_reg   <= gtd_pkg::YT_W'(s5_y2_reg);
        s6_x_reg    <= s6_x;
        s6_q0_reg   <= gtd_pkg::N_W'(s6_xq >> 36);

        s7_side_reg.last <= s6_last_reg;
        s7_side_reg.neg  <= s6_neg_reg;
        s7_side_reg.sat  <= s6_sat_reg;
        s7_side_reg.y2m  <= s6_y2_reg;
        s7_side_reg.n    <= s7_n_next;
        s7_r_reg         <= s7_r_next;
    end

    // ------------------------------------------------------------------
    // Horner chain: exp(-r), one cell per series term, k = 12 down to 1
    // ------------------------------------------------------------------
    logic                        ex_valid [gtd_pkg::EXP_TERMS+1];
    gtd_pkg::side_t              ex_side  [gtd_pkg::EXP_TERMS+1];
    logic [gtd_pkg::R_W-1:0]     ex_r     [gtd_pkg::EXP_TERMS+1];
    logic [gtd_pkg::ACC_W-1:0]   ex_acc   [gtd_pkg::EXP_TERMS+1];

    assign ex_valid[0] = s7_valid_reg;
    assign ex_side[0]  = s7_side_reg;
    assign ex_r[0]     = s7_r_reg;
    assign ex_acc[0]   = gtd_pkg::ONE_Q30;

    for (genvar i = 0; i < gtd_pkg::EXP_TERMS; i++)
    begin : g_exp
        gtd_exp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .k         (gtd_pkg::K_W'(gtd_pkg::EXP_TERMS - i)),
            .valid_in  (ex_valid[i]),
            .side_in   (ex_side[i]),
            .r_in      (ex_r[i]),
            .acc_in    (ex_acc[i]),
            .valid_out (ex_valid[i+1]),
            .side_out  (ex_side[i+1]),
            .r_out     (ex_r[i+1]),
            .acc_out   (ex_acc[i+1])
        );
    end

    // ------------------------------------------------------------------
    // g = rshr(e, n) = exp(-|y1|)
    // ------------------------------------------------------------------
    logic [gtd_pkg::D_W-1:0]    g_half;
    logic [gtd_pkg::ACC_W-1:0]  g_next;
    logic                       g_valid_reg;
    gtd_pkg::side_t             g_side_reg;
    logic [gtd_pkg::ACC_W-1:0]  g_reg;

    assign g_half = (ex_side[gtd_pkg::EXP_TERMS].n == '0) ? '0
                  : gtd_pkg::D_W'(1) << (ex_side[gtd_pkg::EXP_TERMS].n - gtd_pkg::N_W'(1));
    assign g_next = gtd_pkg::ACC_W'((gtd_pkg::D_W'(ex_acc[gtd_pkg::EXP_TERMS]) + g_half)
                    >> ex_side[gtd_pkg::EXP_TERMS].n);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else
            g_valid_reg <= ex_valid[gtd_pkg::EXP_TERMS];
    end

    always_ff @(posedge clk)
    begin
        g_side_reg <= ex_side[gtd_pkg::EXP_TERMS];
        g_reg      <= g_next;
    end

    // ------------------------------------------------------------------
    // Division chain: lo = (g << 30) / (2^30 + g), one quotient bit a cell
    // ------------------------------------------------------------------
    logic                        dv_valid [gtd_pkg::DIV_BITS+1];
    gtd_pkg::side_t              dv_side  [gtd_pkg::DIV_BITS+1];
    logic [gtd_pkg::D_W-1:0]     dv_d     [gtd_pkg::DIV_BITS+1];
    logic [gtd_pkg::D_W-1:0]     dv_rem   [gtd_pkg::DIV_BITS+1];
    logic [gtd_pkg::LO_W-1:0]    dv_quo   [gtd_pkg::DIV_BITS+1];

    assign dv_valid[0] = g_valid_reg;
    assign dv_side[0]  = g_side_reg;
    assign dv_d[0]     = gtd_pkg::D_W'(gtd_pkg::ONE_Q30) + gtd_pkg::D_W'(g_reg);
    assign dv_rem[0]   = gtd_pkg::D_W'(g_reg);
    assign dv_quo[0]   = '0;

    for (genvar j = 0; j < gtd_pkg::DIV_BITS; j++)
    begin : g_div
        gtd_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dv_valid[j]),
            .side_in   (dv_side[j]),
            .d_in      (dv_d[j]),
            .rem_in    (dv_rem[j]),
            .quo_in    (dv_quo[j]),
            .valid_out (dv_valid[j+1]),
            .side_out  (dv_side[j+1]),
            .d_out     (dv_d[j+1]),
            .rem_out   (dv_rem[j+1]),
            .quo_out   (dv_quo[j+1])
        );
    end

    // ------------------------------------------------------------------
    // b1: s and q = s*(1-s)
    // ------------------------------------------------------------------
    localparam int LH_W = gtd_pkg::LO_W + gtd_pkg::ACC_W;
    localparam int QQ_W = 29;
    logic [gtd_pkg::LO_W-1:0]   b1_lo;
    logic [gtd_pkg::ACC_W-1:0]  b1_hi;
    logic [LH_W-1:0]            b1_lh;
    logic                       b1_valid_reg;
    gtd_pkg::side_t             b1_side_reg;
    logic [gtd_pkg::ACC_W-1:0]  b1_s_reg;
    logic [QQ_W-1:0]            b1_q_reg;

    assign b1_lo = dv_quo[gtd_pkg::DIV_BITS];
    assign b1_hi = gtd_pkg::ONE_Q30 - gtd_pkg::ACC_W'(b1_lo);
    assign b1_lh = LH_W'(b1_lo) * LH_W'(b1_hi);

    // ------------------------------------------------------------------
    // b2: t = rshr(|y2| * q, 24)
    // ------------------------------------------------------------------
    localparam int YQP_W = gtd_pkg::YT_W + QQ_W;
    localparam int T_W   = 35;
    logic [YQP_W-1:0]           b2_yq;
    logic                       b2_valid_reg;
    gtd_pkg::side_t             b2_side_reg;
    logic [gtd_pkg::ACC_W-1:0]  b2_s_reg;
    logic [T_W-1:0]             b2_t_reg;

    assign b2_yq = YQP_W'(b1_side_reg.y2m) * YQP_W'(b1_q_reg);

    // ------------------------------------------------------------------
    // b3: combine, round to Q2.13, saturate
    // ------------------------------------------------------------------
    localparam int RS_W = T_W + 2;
    localparam int AR_W = RS_W - 17;
    localparam logic [AR_W-1:0] MAXPOS = AR_W'((1 << (SW - 1)) - 1);
    localparam logic [AR_W-1:0] MAXNEG = AR_W'(1 << (SW - 1));
    localparam logic [AR_W-1:0] ONE_OUT = AR_W'(1 << gtd_pkg::OUT_FRAC);
    logic [RS_W-1:0]            b3_res;
    logic                       b3_rneg;
    logic [RS_W-1:0]            b3_abs;
    logic [AR_W-1:0]            b3_a;
    logic [AR_W-1:0]            b3_clip;
    logic [SW-1:0]              b3_bits;
    gtd_pkg::out_t              result_next;
    logic                       done_reg;
    gtd_pkg::out_t              result_reg;

    assign b3_res  = b2_side_reg.neg ? RS_W'(b2_s_reg) - RS_W'(b2_t_reg)
                                     : RS_W'(b2_s_reg) + RS_W'(b2_t_reg);
    assign b3_abs  = b3_res[RS_W-1] ? RS_W'(-b3_res) : b3_res;
    assign b3_rneg = !b2_side_reg.sat && b3_res[RS_W-1];

    always_comb
    begin
        if (b2_side_reg.sat)
            b3_a = b2_side_reg.neg ? '0 : ONE_OUT;
        else
            b3_a = AR_W'((b3_abs + (RS_W'(1) << 16)) >> 17);

        if (b3_rneg)
        begin
            b3_clip = (b3_a > MAXNEG) ? MAXNEG : b3_a;
            b3_bits = SW'(-b3_clip);
        end
        else
        begin
            b3_clip = (b3_a > MAXPOS) ? MAXPOS : b3_a;
            b3_bits = SW'(b3_clip);
        end

        result_next.derivative = $signed(b3_bits);
        result_next.last_out   = b2_side_reg.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            b1_valid_reg <= dv_valid[gtd_pkg::DIV_BITS];
            b2_valid_reg <= b1_valid_reg;
            done_reg     <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b1_side_reg <= dv_side[gtd_pkg::DIV_BITS];
        b1_s_reg    <= dv_side[gtd_pkg::DIV_BITS].neg ? gtd_pkg::ACC_W'(b1_lo) : b1_hi;
        b1_q_reg    <= QQ_W'((b1_lh + (LH_W'(1) << 29)) >> gtd_pkg::EQ);

        b2_side_reg <= b1_side_reg;
        b2_s_reg    <= b1_s_reg;
        b2_t_reg    <= T_W'((b2_yq + (YQP_W'(1) << 23)) >> gtd_pkg::YQ);

        result_reg  <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    `GTD_ASSERT_IMP(a_range_reduce, s7_valid_reg,
        s7_r_reg < gtd_pkg::LN2_Q30 && s7_side_reg.n <= gtd_pkg::N_W'(23))
    `GTD_ASSERT_NXT(a_overflow_value, b2_valid_reg && b2_side_reg.sat,
        result.derivative == '0 || result.derivative == SW'(ONE_OUT))
    `GTD_ASSERT_NXT(a_done_follows, b2_valid_reg, done)

endmodule
`default_nettype wire

[src/gtd_exp_cell.sv]
`default_nettype none
`include "gelu_tanh_derivative_top_defines.svh"
module gtd_exp_cell (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic [gtd_pkg::K_W-1:0]      k,
    input  wire logic                         valid_in,
    input  wire gtd_pkg::side_t               side_in,
    input  wire logic [gtd_pkg::R_W-1:0]      r_in,
    input  wire logic [gtd_pkg::ACC_W-1:0]    acc_in,
    output logic                              valid_out,
    output gtd_pkg::side_t                    side_out,
    output logic [gtd_pkg::R_W-1:0]           r_out,
    output logic [gtd_pkg::ACC_W-1:0]         acc_out
);

    localparam int PA_W = gtd_pkg::R_W + gtd_pkg::ACC_W;
    localparam int PB_W = gtd_pkg::V_W + gtd_pkg::RCP_W;
    localparam int QK_W = gtd_pkg::V_W + gtd_pkg::K_W;

    // stage a: r * acc
    logic                       a_valid_reg;
    gtd_pkg::side_t             a_side_reg;
    logic [gtd_pkg::R_W-1:0]    a_r_reg;
    logic [gtd_pkg::V_W-1:0]    a_v_reg;
    logic [PA_W-1:0]            a_prod;
    logic [gtd_pkg::V_W-1:0]    a_v_next;

    assign a_prod   = PA_W'(r_in) * PA_W'(acc_in);
    assign a_v_next = gtd_pkg::V_W'(a_prod >> gtd_pkg::EQ);

    // stage b: quotient estimate by reciprocal
    logic                       b_valid_reg;
    gtd_pkg::side_t             b_side_reg;
    logic [gtd_pkg::R_W-1:0]    b_r_reg;
    logic [gtd_pkg::V_W-1:0]    b_v_reg;
    logic [gtd_pkg::V_W-1:0]    b_q0_reg;
    logic [PB_W-1:0]            b_prod;
    logic [gtd_pkg::V_W-1:0]    b_q0_next;

    assign b_prod    = PB_W'(a_v_reg) * PB_W'(gtd_pkg::exp_rcp(k));
    assign b_q0_next = gtd_pkg::V_W'(b_prod >> 32);

    // stage c: correct by one and step the Horner accumulator
    logic                       c_valid_reg;
    gtd_pkg::side_t             c_side_reg;
    logic [gtd_pkg::R_W-1:0]    c_r_reg;
    logic [gtd_pkg::ACC_W-1:0]  c_acc_reg;
    logic [QK_W-1:0]            c_rem;
    logic [gtd_pkg::V_W-1:0]    c_q;
    logic [gtd_pkg::ACC_W-1:0]  c_acc_next;

    assign c_rem      = QK_W'(b_v_reg) - QK_W'(b_q0_reg) * QK_W'(k);
    assign c_q        = (c_rem >= QK_W'(k)) ? b_q0_reg + gtd_pkg::V_W'(1) : b_q0_reg;
    assign c_acc_next = gtd_pkg::ONE_Q30 - gtd_pkg::ACC_W'(c_q);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= valid_in;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_side_reg <= side_in;
        a_r_reg    <= r_in;
        a_v_reg    <= a_v_next;
        b_side_reg <= a_side_reg;
        b_r_reg    <= a_r_reg;
        b_v_reg    <= a_v_reg;
        b_q0_reg   <= b_q0_next;
        c_side_reg <= b_side_reg;
        c_r_reg    <= b_r_reg;
        c_acc_reg  <= c_acc_next;
    end

    assign valid_out = c_valid_reg;
    assign side_out  = c_side_reg;
    assign r_out     = c_r_reg;
    assign acc_out   = c_acc_reg;

    `GTD_ASSERT_IMP(a_acc_range, c_valid_reg,
        c_acc_reg != '0 && c_acc_reg <= gtd_pkg::ONE_Q30)

endmodule
`default_nettype wire

[src/gtd_div_cell.sv]
`default_nettype none
`include "gelu_tanh_derivative_top_defines.svh"
module gtd_div_cell (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        valid_in,
    input  wire gtd_pkg::side_t              side_in,
    input  wire logic [gtd_pkg::D_W-1:0]     d_in,
    input  wire logic [gtd_pkg::D_W-1:0]     rem_in,
    input  wire logic [gtd_pkg::LO_W-1:0]    quo_in,
    output logic                             valid_out,
    output gtd_pkg::side_t                   side_out,
    output logic [gtd_pkg::D_W-1:0]          d_out,
    output logic [gtd_pkg::D_W-1:0]          rem_out,
    output logic [gtd_pkg::LO_W-1:0]         quo_out
);

    localparam int RW = gtd_pkg::D_W + 1;

    logic                         valid_reg;
    gtd_pkg::side_t               side_reg;
    logic [gtd_pkg::D_W-1:0]      d_reg;
    logic [gtd_pkg::D_W-1:0]      rem_reg;
    logic [gtd_pkg::LO_W-1:0]     quo_reg;

    logic [RW-1:0]                rem2;
    logic                         ge;
    logic [gtd_pkg::D_W-1:0]      rem_next;
    logic [gtd_pkg::LO_W-1:0]     quo_next;

    // one restoring step: shift, trial subtract, keep the quotient bit
    assign rem2     = {rem_in, 1'b0};
    assign ge       = rem2 >= RW'(d_in);
    assign rem_next = ge ? gtd_pkg::D_W'(rem2 - RW'(d_in)) : gtd_pkg::D_W'(rem2);
    assign quo_next = {quo_in[gtd_pkg::LO_W-2:0], ge};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        side_reg <= side_in;
        d_reg    <= d_in;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
    end

    assign valid_out = valid_reg;
    assign side_out  = side_reg;
    assign d_out     = d_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

    `GTD_ASSERT_IMP(a_rem_below_divisor, valid_in && rem_in < d_in, 1'b1 && rem_next < d_in)

endmodule
`default_nettype wire
